### rtl/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types and character constants for the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

  // Characters that the decoder recognizes
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_C   = 8'h63;
  localparam logic [7:0] CH_X   = 8'h78;

  localparam logic [7:0] COLOUR_RESET = 8'd28;

  // Parser state, one-hot
  typedef enum logic [3:0] {
    MODE_TEXT = 4'b0001,
    MODE_ESC  = 4'b0010,
    MODE_HEX  = 4'b0100,
    MODE_OCT  = 4'b1000
  } esd_mode_t;

  // One output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       string_end;
  } esd_result_t;

  // Decoder result for one input word: up to two output words
  typedef struct packed {
    logic [1:0]  n;
    esd_result_t r0;
    esd_result_t r1;
  } esd_dec_t;

endpackage

### rtl/esd_decode.sv
// ----------------------------------------------------------------------------
// esd_decode
// Parser state and single-pass escape decode of one input byte.
// ----------------------------------------------------------------------------
module esd_decode
  import esd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  input  logic [7:0] colour_code,
  output esd_dec_t   dec
);

  esd_mode_t  mode, mode_next;
  logic [7:0] acc, acc_next;
  logic [1:0] cnt, cnt_next;

  esd_mode_t  mode_mid;
  logic [7:0] acc_mid;
  logic [1:0] cnt_mid;
  logic [7:0] v0, v1;
  logic [1:0] n;
  logic       end_str;
  logic       hex_ok;
  logic [3:0] hex_d;
  logic       oct_ok;
  logic [7:0] acc_hex, acc_oct;

  // Hex digit classify
  always_comb begin
    hex_ok = 1'b0;
    hex_d  = data_byte[3:0];
    if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
      hex_ok = 1'b1;
    end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
                 (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
      hex_ok = 1'b1;
      hex_d  = data_byte[3:0] + 4'd9;
    end
  end

  assign oct_ok  = (data_byte[7:3] == 5'b00110);
  assign acc_hex = {acc[3:0], hex_d};
  assign acc_oct = {acc[4:0], data_byte[2:0]};
  assign end_str = (data_byte == 8'd0) || is_last;

  always_comb begin
    mode_mid = mode;
    acc_mid  = acc;
    cnt_mid  = cnt;
    v0       = '0;
    v1       = '0;
    n        = 2'd0;
    if (data_byte != 8'd0) begin
      unique case (mode)
        MODE_TEXT: begin
          if (data_byte == CH_BSL) begin
            mode_mid = MODE_ESC;
          end else begin
            v0 = data_byte;
            n  = 2'd1;
          end
        end
        MODE_ESC: begin
          mode_mid = MODE_TEXT;
          priority if (data_byte == CH_T) begin
            v0 = CH_TAB;
            n  = 2'd1;
          end else if (data_byte == CH_N) begin
            v0 = CH_LF;
            n  = 2'd1;
          end else if (data_byte == CH_R) begin
            v0 = CH_CR;
            n  = 2'd1;
          end else if (data_byte == CH_C) begin
            v0 = colour_code;
            n  = 2'd1;
          end else if (data_byte == CH_X) begin
            mode_mid = MODE_HEX;
            acc_mid  = '0;
            cnt_mid  = 2'd0;
          end else if (oct_ok) begin
            mode_mid = MODE_OCT;
            acc_mid  = {5'd0, data_byte[2:0]};
            cnt_mid  = 2'd1;
          end else if (data_byte == CH_LF) begin
            // line continuation: drop both bytes
            mode_mid = MODE_TEXT;
          end else begin
            v0 = data_byte;
            n  = 2'd1;
          end
        end
        MODE_HEX, MODE_OCT: begin
          if ((mode == MODE_HEX) ? hex_ok : oct_ok) begin
            acc_mid = (mode == MODE_HEX) ? acc_hex : acc_oct;
            cnt_mid = cnt + 2'd1;
            if ((mode == MODE_HEX) ? (cnt == 2'd1) : (cnt == 2'd2)) begin
              v0       = acc_mid;
              n        = 2'd1;
              mode_mid = MODE_TEXT;
              acc_mid  = '0;
              cnt_mid  = 2'd0;
            end
          end else begin
            // emit the value, then treat this byte as text
            v0      = acc;
            acc_mid = '0;
            cnt_mid = 2'd0;
            if (data_byte == CH_BSL) begin
              mode_mid = MODE_ESC;
              n        = 2'd1;
            end else begin
              mode_mid = MODE_TEXT;
              v1       = data_byte;
              n        = 2'd2;
            end
          end
        end
        default: begin
          mode_mid = MODE_TEXT;
        end
      endcase
    end
    // flush a pending numeric value at end of string
    if (end_str && (mode_mid == MODE_HEX || mode_mid == MODE_OCT)) begin
      if (n == 2'd0) begin
        v0 = acc_mid;
        n  = 2'd1;
      end else begin
        v1 = acc_mid;
        n  = 2'd2;
      end
    end
  end

  always_comb begin
    mode_next = mode_mid;
    acc_next  = acc_mid;
    cnt_next  = cnt_mid;
    if (end_str) begin
      mode_next = MODE_TEXT;
      acc_next  = '0;
      cnt_next  = 2'd0;
    end
    dec.r0.out_byte   = v0;
    dec.r0.has_byte   = (n != 2'd0);
    dec.r0.run_last   = (n != 2'd2);
    dec.r0.string_end = end_str && (n != 2'd2);
    dec.r1.out_byte   = v1;
    dec.r1.has_byte   = 1'b1;
    dec.r1.run_last   = 1'b1;
    dec.r1.string_end = end_str;
    dec.n             = (n == 2'd0) ? {1'b0, end_str} : n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_TEXT;
      acc  <= '0;
      cnt  <= 2'd0;
    end else if (advance) begin
      mode <= mode_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    advance && end_str |=> mode == MODE_TEXT && acc == 8'd0 && cnt == 2'd0)
    else $error("parser state not cleared after end of string");

  a_text_no_count: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_TEXT || mode == MODE_ESC) |-> cnt == 2'd0 && acc == 8'd0)
    else $error("digit state left over outside a numeric escape");

endmodule

### rtl/escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Expands backslash escapes in a byte stream, one input word per cycle unless stalled.
// ----------------------------------------------------------------------------
// An accepted input word's output words are written into the output queue as it is taken.
// Throughput: one input word per cycle while not stalled; a word that expands into two output
//   words takes two slots of the output queue, which drains one word a cycle unless out_stall is high.
// Input stalls while fewer than two queue slots are free (queue depth FIFO_DEPTH).
// Reset (rst, synchronous): parser to plain text, queue empty, colour code 0x1C.
module escape_sequence_decoder
  import esd_pkg::*;
#(
  parameter int FIFO_DEPTH = 4  // power of two, at least 2
) (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       run_last,
  output logic       string_end,
  // colour code register write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [7:0]       colour_code;
  esd_dec_t         dec;
  logic             accept;
  logic             pop;
  logic [1:0]       push_n;

  esd_result_t      queue [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  esd_result_t      head;

  // Config register: always ready; user must write it only while idle (the block does not enforce it)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_code <= COLOUR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      colour_code <= cfg_data;
    end
  end

  // Input side: take a word only when the queue can hold both possible results
  assign in_stall = (count > CNT_W'(FIFO_DEPTH - 2));
  assign accept   = in_valid && !in_stall;

  esd_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .data_byte   (data_byte),
    .is_last     (is_last),
    .colour_code (colour_code),
    .dec         (dec)
  );

  // Words to push this cycle: zero, one, or two
  assign push_n = accept ? dec.n : 2'd0;

  // Output queue: two writes, one read at the head
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= dec.r0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + PTR_W'(1)] <= dec.r1;
    end
  end

  assign head       = queue[rd_ptr];
  assign out_valid  = (count != '0);
  assign pop        = out_valid && !out_stall;
  assign out_byte   = head.out_byte;
  assign has_byte   = head.has_byte;
  assign run_last   = head.run_last;
  assign string_end = head.string_end;

  assign count_next = count + CNT_W'(push_n) - CNT_W'(pop);

  // Advance pointers; hold when idle
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_last)
    else $error("string end without run last");

  a_marker_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> out_byte == 8'd0 && string_end)
    else $error("bare marker carries a byte or is not a string end");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    accept && dec.n == 2'd0 && !pop |=> $stable(count))
    else $error("queue count moved without a push or pop");

endmodule

### tb/sv/esd_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// esd_tb_pkg
// Scoreboard for the escape sequence decoder: predicts the output words of
// every accepted input word and checks the block's output words in order.
// ----------------------------------------------------------------------------
package esd_tb_pkg;
  import esd_pkg::*;

  class decode_scoreboard;
    esd_mode_t   mode;
    logic [7:0]  accum;
    logic [1:0]  digits;
    logic [7:0]  colour;
    esd_result_t expected_words[$];
    int          mismatches;

    function new();
      colour     = COLOUR_RESET;
      mismatches = 0;
      clear_escape();
    endfunction

    function void clear_escape();
      mode   = MODE_TEXT;
      accum  = '0;
      digits = '0;
    endfunction

    // Expand one accepted input word into the output words it must produce
    function void take_input(logic [7:0] b, logic last);
      logic [7:0]  bytes[$];
      logic        ends;
      logic        as_text;
      logic [4:0]  nib;
      esd_result_t r;
      as_text = 1'b0;
      nib     = 5'd16;
      ends    = (b == 8'h00) || last;
      if (b != 8'h00) begin
        case (mode)
          MODE_ESC: begin
            mode = MODE_TEXT;
            case (b)
              CH_T: bytes.push_back(CH_TAB);
              CH_N: bytes.push_back(CH_LF);
              CH_R: bytes.push_back(CH_CR);
              CH_C: bytes.push_back(colour);
              CH_X: begin
                mode   = MODE_HEX;
                accum  = '0;
                digits = '0;
              end
              CH_LF: ;  // line continuation: nothing out
              default: begin
                if (b >= "0" && b <= "7") begin
                  mode   = MODE_OCT;
                  accum  = b - "0";
                  digits = 2'd1;
                end else begin
                  bytes.push_back(b);
                end
              end
            endcase
          end
          MODE_HEX: begin
            if (b >= "0" && b <= "9") nib = 5'(b - "0");
            else if (b >= "a" && b <= "f") nib = 5'(b - "a" + 8'd10);
            else if (b >= "A" && b <= "F") nib = 5'(b - "A" + 8'd10);
            if (nib[4]) begin
              bytes.push_back(accum);
              clear_escape();
              as_text = 1'b1;
            end else begin
              accum  = {accum[3:0], nib[3:0]};
              digits = digits + 2'd1;
              if (digits == 2'd2) begin
                bytes.push_back(accum);
                clear_escape();
              end
            end
          end
          MODE_OCT: begin
            if (b >= "0" && b <= "7") begin
              accum  = {accum[4:0], b[2:0]};
              digits = digits + 2'd1;
              if (digits == 2'd3) begin
                bytes.push_back(accum);
                clear_escape();
              end
            end else begin
              bytes.push_back(accum);
              clear_escape();
              as_text = 1'b1;
            end
          end
          default: as_text = 1'b1;
        endcase
        if (as_text) begin
          if (b == CH_BSL) mode = MODE_ESC;
          else bytes.push_back(b);
        end
      end
      // End of string: flush a pending number, drop a lone backslash
      if (ends) begin
        if (mode == MODE_HEX || mode == MODE_OCT) bytes.push_back(accum);
        clear_escape();
      end
      foreach (bytes[k]) begin
        r.out_byte   = bytes[k];
        r.has_byte   = 1'b1;
        r.run_last   = (k == bytes.size() - 1);
        r.string_end = ends && r.run_last;
        expected_words.push_back(r);
      end
      if (ends && bytes.size() == 0) begin
        r            = '0;
        r.run_last   = 1'b1;
        r.string_end = 1'b1;
        expected_words.push_back(r);
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 100) $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task check_output(logic [7:0] out_byte, logic has_byte, logic run_last,
                      logic string_end);
      esd_result_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word out_byte=%h has_byte=%b", out_byte, has_byte));
        return;
      end
      want = expected_words.pop_front();
      if (out_byte !== want.out_byte)
        report($sformatf("out_byte %h, want %h", out_byte, want.out_byte));
      if (has_byte !== want.has_byte)
        report($sformatf("has_byte %b, want %b", has_byte, want.has_byte));
      if (run_last !== want.run_last)
        report($sformatf("run_last %b, want %b", run_last, want.run_last));
      if (string_end !== want.string_end)
        report($sformatf("string_end %b, want %b", string_end, want.string_end));
    endtask
  endclass

endpackage

### tb/sv/escape_sequence_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escape_sequence_decoder_tb
// Drives text words through the escape sequence decoder, first a directed set
// of escapes and end-of-string cases, then random escape fragments mixed with
// noise, under several colour codes and with random idle and stall bursts.
// Every output word is checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_tb;
  import esd_pkg::*;
  import esd_tb_pkg::*;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte  = 8'h00;
  logic       is_last    = 1'b0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       run_last;
  logic       string_end;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data   = 8'h00;

  bit idle_on    = 1'b1;  // allow idle bursts on both sides
  int words_sent = 0;

  decode_scoreboard sb = new();

  escape_sequence_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .is_last    (is_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .run_last   (run_last),
    .string_end (string_end),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both channels; values read here are the ones the block saw at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.take_input(data_byte, is_last);
      if (out_valid && !out_stall) sb.check_output(out_byte, has_byte, run_last, string_end);
    end
  end

  // Receiver: stall in random bursts while idling is allowed
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic rand_last();
    return $urandom_range(0, 11) == 0;
  endfunction

  // Offer one word, maybe after an idle burst, and hold it until accepted
  task automatic send_word(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    is_last   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Send a string; mark its last character as end of string if asked
  task automatic send_text(input string s, input logic end_last);
    for (int i = 0; i < s.len(); i++) send_word(s[i], end_last && (i == s.len() - 1));
  endtask

  // Drain the block, let trailing no-result words settle, then write the code
  task automatic write_colour(input logic [7:0] code);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.colour = code;
  endtask

  // One random fragment: mostly well-formed escapes, some plain noise and
  // zero words; is_last falls anywhere, so escapes get cut short too
  task automatic send_fragment();
    string hex_chars = "0123456789abcdefABCDEF";
    string esc_chars = "tnrc\nq\\\"a8";
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_word(CH_BSL, rand_last());
      if ($urandom_range(0, 4) == 0) send_word(8'($urandom_range(1, 255)), rand_last());
      else send_word(esc_chars[$urandom_range(0, esc_chars.len() - 1)], rand_last());
    end else if (pick < 55) begin
      send_word(CH_BSL, rand_last());
      send_word(CH_X, rand_last());
      repeat ($urandom_range(0, 3))
        send_word(hex_chars[$urandom_range(0, hex_chars.len() - 1)], rand_last());
    end else if (pick < 70) begin
      send_word(CH_BSL, rand_last());
      send_word(8'("0" + $urandom_range(0, 7)), rand_last());
      repeat ($urandom_range(0, 3)) send_word(8'("0" + $urandom_range(0, 7)), rand_last());
    end else if (pick < 95) begin
      send_word(8'($urandom_range(1, 255)), rand_last());
    end else begin
      send_word(8'h00, rand_last());
    end
  endtask

  task automatic run_random(input int count);
    int stop;
    stop = words_sent + count;
    while (words_sent < stop) send_fragment();
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: named escapes with the reset colour code, line continuation
    send_text("\\t\\c\\\n", 1'b0);
    // Two hex digits, then a hex escape broken by a non-digit
    send_text("\\x4f\\xG", 1'b0);
    // Octal wrap past 255, then an octal escape ended early by '9'
    send_text("\\777\\59", 1'b0);
    // Top byte value, ending the string
    send_word(8'hFF, 1'b1);
    // Zero right after a backslash: drop the backslash, end the string
    send_text("\\", 1'b0);
    send_word(8'h00, 1'b0);
    // Lone trailing backslash gives a bare end marker
    send_text("\\", 1'b1);
    // End of string flushes an empty hex escape, then a partial octal one
    send_text("\\x", 1'b1);
    send_text("\\12", 1'b1);
    // Zero word flagged last: end marker only
    send_word(8'h00, 1'b1);

    // Random phases under the extreme and some middle colour codes
    write_colour(8'h00);
    run_random(70);
    write_colour(8'hFF);
    idle_on = 1'b0;
    run_random(50);
    idle_on = 1'b1;
    write_colour(8'($urandom_range(1, 254)));
    run_random(70);
    write_colour(COLOUR_RESET);
    idle_on = 1'b0;  // last part runs flat out
    run_random(60);

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
